// File: hw/rtl/rpa_pkg.sv
// Shared types and constants for the refcounted page allocator.
// No dependencies; imported by every module of the block but rpa_ram.
package rpa_pkg;

  // Default geometry
  localparam int MAX_PAGES_DEF  = 1024;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int COUNT_BITS_DEF = 16;

  // Field widths fixed by the interface
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;
  localparam int CFG_IW = 2;
  localparam int PCW    = 11;

  // Reset value of page_count
  localparam logic [PCW-1:0] PC_RESET = 11'd1024;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP  = 3'd2;
  localparam logic [OP_W-1:0] OP_RSV   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_NOMEM = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd2;
  localparam logic [ST_W-1:0] ST_NALLOC = 3'd3;
  localparam logic [ST_W-1:0] ST_SAT   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_BASE   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PCOUNT = 2'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic cfg_wr;
    logic load;
    logic init_clr;
    logic init_wr;
    logic dec_fail;
    logic exec;
    logic rd_cnt;
    logic chk_start;
    logic chk_next;
    logic chk_fail;
    logic rb_start;
    logic rb_step;
    logic push;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_rsv;
    logic dec_ok;
    logic chk_busy;
    logic chk_last;
    logic rb_last;
    logic init_last;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/rpa_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module rpa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rpa_ctrl.sv
// Sequencer for the page allocator: init sweep, op decode, reserve scan.
// Depends on rpa_pkg (cmd_t, stat_t, codes).
module rpa_ctrl import rpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              cfg_valid,
  input  logic [CFG_IW-1:0] cfg_index,
  input  stat_t             stat,
  output cmd_t              cmd,
  output logic              in_ready,
  output logic              cfg_ready
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_EXEC   = 4'd3;
  localparam logic [3:0] S_CHK_RD = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_RB_RD  = 4'd6;
  localparam logic [3:0] S_RB     = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
          if (cfg_index == CFG_PCOUNT) begin
            cmd.init_clr = 1'b1;
            state_next   = S_INIT;
          end
        end else if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat.dec_ok) begin
          cmd.dec_fail = 1'b1;
          state_next   = S_DONE;
        end else if (stat.is_rsv) begin
          cmd.chk_start = 1'b1;
          state_next    = S_CHK_RD;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
      end
      S_CHK_RD: begin
        cmd.rd_cnt = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.chk_busy) begin
          cmd.chk_fail = 1'b1;
          state_next   = S_DONE;
        end else if (stat.chk_last) begin
          cmd.rb_start = 1'b1;
          state_next   = S_RB_RD;
        end else begin
          cmd.chk_next = 1'b1;
          state_next   = S_CHK_RD;
        end
      end
      S_RB_RD: begin
        cmd.rd_cnt = 1'b1;
        state_next = S_RB;
      end
      S_RB: begin
        cmd.rb_step = 1'b1;
        state_next  = stat.rb_last ? S_DONE : S_RB_RD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

// File: hw/rtl/rpa_dp.sv
// Datapath of the page allocator: config regs, address decode, page table,
// free list head and count, result and output registers.
// Depends on rpa_pkg and rpa_ram.
module rpa_dp import rpa_pkg::*; #(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output stat_t                         stat,
  input  logic [CFG_IW-1:0]             cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [OP_W-1:0]               op,
  input  logic [31:0]                   addr,
  input  logic [31:0]                   end_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ST_W-1:0]               status,
  output logic [31:0]                   page_addr,
  output logic [COUNT_BITS-1:0]         ref_count,
  output logic                          in_range,
  output logic [$clog2(MAX_PAGES+1)-1:0] free_pages
);

  localparam int IDXW = $clog2(MAX_PAGES);
  localparam int NW   = $clog2(MAX_PAGES + 1);
  localparam int PS   = $clog2(PAGE_BYTES);
  localparam int PW   = 32 - PS;
  localparam int VW   = (COUNT_BITS > IDXW) ? COUNT_BITS : IDXW;
  localparam int EW   = VW + 1;
  localparam int BW   = (PW > NW) ? PW : NW;
  localparam int LW   = BW + 2;
  localparam logic [VW-1:0] CMAX = VW'((64'd1 << COUNT_BITS) - 64'd1);

  logic [31:0]           region_base;
  logic [PCW-1:0]        page_count;
  logic [IDXW-1:0]       head, head_n;
  logic [NW-1:0]         total, total_n;
  logic [IDXW-1:0]       cnt, prev, prev_n;
  logic [NW-1:0]         tot, tot_n;
  logic [OP_W-1:0]       op_r;
  logic [31:0]           addr_r, end_r;
  logic [ST_W-1:0]       res_status, ex_status;
  logic [31:0]           res_addr;
  logic [COUNT_BITS-1:0] res_rc, ex_rc;

  // Live page count, clipped to 1..MAX_PAGES
  logic [LW-1:0] pc_l, live_l;
  logic [NW-1:0] n;
  assign pc_l   = LW'(page_count);
  assign live_l = (pc_l == '0) ? LW'(1) :
                  ((pc_l > LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : pc_l);
  assign n      = live_l[NW-1:0];

  // Address decode in page units
  logic [LW-1:0] bp_l, ap_l, diff_l, sp_l, ep_l, endp_l, p_l, last_l, cnt_l;
  logic          idx_ok, rsv_ok;
  logic [IDXW-1:0] idx;
  assign bp_l   = LW'(region_base[31:PS]);
  assign ap_l   = LW'(addr_r[31:PS]);
  assign diff_l = ap_l - bp_l;
  assign idx_ok = (ap_l >= bp_l) && (diff_l < live_l);
  assign idx    = diff_l[IDXW-1:0];
  assign sp_l   = ap_l + LW'(addr_r[PS-1:0] != '0);
  assign ep_l   = LW'(end_r[31:PS]);
  assign endp_l = bp_l + live_l;
  assign rsv_ok = (ep_l > sp_l) && (sp_l >= bp_l) && (ep_l <= endp_l);
  assign p_l    = sp_l - bp_l;
  assign last_l = ep_l - bp_l - LW'(1);
  assign cnt_l  = LW'(cnt);

  logic is_alloc, is_add, is_drop, is_rsv;
  assign is_alloc = (op_r == OP_ALLOC);
  assign is_add   = (op_r == OP_ADD);
  assign is_drop  = (op_r == OP_DROP);
  assign is_rsv   = (op_r == OP_RSV);

  // Page table
  logic            we;
  logic [IDXW-1:0] waddr, raddr;
  logic [EW-1:0]   wdata, rdata;
  logic            e_free;
  logic [VW-1:0]   e_val;
  assign raddr  = cmd.rd_cnt ? cnt : (is_alloc ? head : idx);
  assign e_free = rdata[VW];
  assign e_val  = rdata[VW-1:0];

  rpa_ram #(.W(EW), .D(MAX_PAGES)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Single-page operation on the entry just read
  logic          ex_we;
  logic [EW-1:0] ex_wdata;
  logic [LW-1:0] pa_l;
  assign pa_l = bp_l + LW'(head);
  always_comb begin
    ex_we     = 1'b0;
    ex_wdata  = rdata;
    ex_status = ST_OK;
    ex_rc     = '0;
    head_n    = head;
    total_n   = total;
    if (is_alloc) begin
      ex_we    = 1'b1;
      ex_wdata = {1'b0, VW'(1)};
      head_n   = e_val[IDXW-1:0];
      total_n  = total - NW'(1);
      ex_rc    = COUNT_BITS'(1);
    end else if (is_add || is_drop) begin
      if (e_free) begin
        ex_status = ST_NALLOC;
      end else if (is_add) begin
        if (e_val >= CMAX) begin
          ex_status = ST_SAT;
          ex_rc     = e_val[COUNT_BITS-1:0];
        end else begin
          ex_we    = 1'b1;
          ex_wdata = {1'b0, e_val + VW'(1)};
          ex_rc    = COUNT_BITS'(e_val + VW'(1));
        end
      end else if (e_val <= VW'(1)) begin
        ex_we    = 1'b1;
        ex_wdata = {1'b1, VW'(head)};
        head_n   = idx;
        total_n  = total + NW'(1);
      end else begin
        ex_we    = 1'b1;
        ex_wdata = {1'b0, e_val - VW'(1)};
        ex_rc    = COUNT_BITS'(e_val - VW'(1));
      end
    end else begin
      ex_rc = e_free ? '0 : e_val[COUNT_BITS-1:0];
    end
  end

  // Rebuild step: mark reserved pages, relink free ones downward
  logic          rb_we, rb_in;
  logic [EW-1:0] rb_wdata;
  assign rb_in = (cnt_l >= p_l) && (cnt_l <= last_l);
  always_comb begin
    rb_we    = 1'b0;
    rb_wdata = {1'b0, VW'(1)};
    prev_n   = prev;
    tot_n    = tot;
    if (rb_in) begin
      rb_we = 1'b1;
    end else if (e_free) begin
      rb_we    = 1'b1;
      rb_wdata = {1'b1, VW'(prev)};
      prev_n   = cnt;
      tot_n    = tot + NW'(1);
    end
  end

  // Init sweep entry
  logic [LW-1:0] nxt_l;
  logic [EW-1:0] init_wdata;
  assign nxt_l      = cnt_l + LW'(1);
  assign init_wdata = (cnt_l < live_l) ?
                      {1'b1, (nxt_l < live_l) ? VW'(nxt_l) : VW'(0)} : '0;

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = init_wdata;
    if (cmd.init_wr) begin
      we = 1'b1;
    end else if (cmd.exec) begin
      we    = ex_we;
      waddr = is_alloc ? head : idx;
      wdata = ex_wdata;
    end else if (cmd.rb_step) begin
      we    = rb_we;
      wdata = rb_wdata;
    end
  end

  // Control-state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      page_count  <= PC_RESET;
      head        <= '0;
      total       <= '0;
      cnt         <= '0;
      prev        <= '0;
      tot         <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        if (cfg_index == CFG_BASE)   region_base <= cfg_data;
        if (cfg_index == CFG_PCOUNT) page_count  <= cfg_data[PCW-1:0];
      end
      if (cmd.init_clr) cnt <= '0;
      if (cmd.init_wr) begin
        cnt   <= cnt + IDXW'(1);
        head  <= '0;
        total <= n;
      end
      if (cmd.exec) begin
        head  <= head_n;
        total <= total_n;
      end
      if (cmd.chk_start) cnt <= p_l[IDXW-1:0];
      if (cmd.chk_next)  cnt <= cnt + IDXW'(1);
      if (cmd.rb_start) begin
        cnt  <= '0;
        prev <= '0;
        tot  <= '0;
      end
      if (cmd.rb_step) begin
        cnt  <= cnt + IDXW'(1);
        prev <= prev_n;
        tot  <= tot_n;
        if (stat.rb_last) begin
          head  <= prev_n;
          total <= tot_n;
        end
      end
    end
  end

  // Input beat and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= op;
      addr_r     <= addr;
      end_r      <= end_addr;
      res_addr   <= addr;
      res_status <= ST_OK;
      res_rc     <= '0;
    end
    if (cmd.dec_fail) begin
      res_rc <= '0;
      if (is_alloc)               res_status <= ST_NOMEM;
      else if (is_add || is_drop) res_status <= ST_RANGE;
      else if (is_rsv)            res_status <= ST_RANGE;
      else                        res_status <= ST_OK;
    end
    if (cmd.exec) begin
      res_status <= ex_status;
      res_rc     <= ex_rc;
      if (is_alloc) res_addr <= {pa_l[PW-1:0], PS'(0)};
    end
    if (cmd.chk_fail) res_status <= ST_NOMEM;
    if (cmd.rb_step && stat.rb_last) res_rc <= COUNT_BITS'(1);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      status     <= res_status;
      page_addr  <= res_addr;
      ref_count  <= res_rc;
      in_range   <= idx_ok;
      free_pages <= total;
    end
  end

  // Status to controller
  always_comb begin
    stat.is_rsv    = is_rsv;
    stat.dec_ok    = is_alloc ? (total != '0) : (is_rsv ? rsv_ok : idx_ok);
    stat.chk_busy  = !e_free;
    stat.chk_last  = (cnt_l == last_l);
    stat.rb_last   = (cnt_l == live_l - LW'(1));
    stat.init_last = (cnt_l == LW'(MAX_PAGES - 1));
    stat.out_free  = !out_valid || out_ready;
  end

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    !cmd.init_wr |-> (LW'(total) <= live_l))
    else $error("free page total exceeds live page count");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready))
    else $error("result pushed over an untaken beat");

  a_alloc_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_alloc) |=> (total == $past(total) - NW'(1)))
    else $error("allocate did not take one page from the pool");

endmodule

// File: hw/rtl/refcounted_page_allocator_core.sv
// Top level of the refcounted page allocator: controller plus datapath.
// Depends on rpa_pkg, rpa_ctrl, rpa_dp (and rpa_ram below it).
//
//  channel | direction | beat fields
//  --------+-----------+----------------------------------------------------
//  in      | input     | op, addr, end_addr
//  out     | output    | status, page_addr, ref_count, in_range, free_pages
//  cfg     | input     | cfg_index, cfg_data (0 region_base, 1 page_count)
//
// Allocate, reference ops and query: decode with table read, write-back,
// output load; the next input beat is taken only after the output load, so
// one item is in flight at a time. A beat that fails decode skips the
// write-back. Reserve: decode, then a table read and a check per page checked,
// then on success a table read and a rebuild step per live page; the check
// stops at the first busy page. Reset and every page_count write start a
// sweep over all MAX_PAGES entries that rebuilds the table, taking no input
// beat; a result waiting in the output register stalls only the final load.
module refcounted_page_allocator_core import rpa_pkg::*; #(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [OP_W-1:0]                op,
  input  logic [31:0]                    addr,
  input  logic [31:0]                    end_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ST_W-1:0]                status,
  output logic [31:0]                    page_addr,
  output logic [COUNT_BITS-1:0]          ref_count,
  output logic                           in_range,
  output logic [$clog2(MAX_PAGES+1)-1:0] free_pages,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IW-1:0]              cfg_index,
  input  logic [31:0]                    cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  rpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready),
    .cfg_ready(cfg_ready)
  );

  rpa_dp #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_BYTES(PAGE_BYTES),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .addr      (addr),
    .end_addr  (end_addr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .page_addr (page_addr),
    .ref_count (ref_count),
    .in_range  (in_range),
    .free_pages(free_pages)
  );

endmodule

// File: verif/tb_refcounted_page_allocator_core.sv
// Self-checking testbench for refcounted_page_allocator_core.
// Depends on rpa_pkg and the block's RTL; holds its own page-table predictor.
`timescale 1ns / 100ps

module tb_refcounted_page_allocator_core;
  import rpa_pkg::*;

  localparam int NPG = MAX_PAGES_DEF;
  localparam int PGB = PAGE_BYTES_DEF;
  localparam int CNTMAX = (1 << COUNT_BITS_DEF) - 1;
  localparam int LIMIT = 8000000;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [31:0]     page_addr;
    logic [15:0]     ref_count;
    logic            in_range;
    logic [10:0]     free_pages;
  } result_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic [OP_W-1:0] op = OP_QUERY;
  logic [31:0] addr = 0, end_addr = 0, cfg_data = 0;
  logic [CFG_IW-1:0] cfg_index = CFG_BASE;
  logic in_ready, out_valid, cfg_ready, in_range;
  logic [ST_W-1:0] status;
  logic [31:0] page_addr;
  logic [15:0] ref_count;
  logic [10:0] free_pages;

  refcounted_page_allocator_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  bit          pg_free[NPG];
  int unsigned pg_val[NPG];
  int unsigned fl_head, fl_total;
  logic [31:0] base_reg;
  int unsigned npages;
  result_t     expected_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          in_idle_pct = 29, out_idle_pct = 29;
  bit          hold_out = 0;

  function automatic longint unsigned base_al();
    return (longint'(base_reg) / PGB) * PGB;
  endfunction

  function automatic void rebuild_chain();
    for (int i = 0; i < NPG; i++) begin
      pg_free[i] = i < npages;
      pg_val[i] = (i < npages && i + 1 < npages) ? i + 1 : 0;
    end
    fl_head = 0;
    fl_total = npages;
  endfunction

  function automatic result_t predict_op(logic [2:0] o, logic [31:0] a, logic [31:0] e);
    result_t r;
    longint unsigned b, rend, s, en;
    longint idx;
    int unsigned h, p, sz, prev, tot;
    bit busy;
    b = base_al();
    rend = b + longint'(npages) * PGB;
    idx = (a < b || a >= rend) ? -1 : (longint'(a) - b) / PGB;
    r = '0;
    r.status = ST_OK;
    r.page_addr = a;
    if (o == OP_ALLOC) begin
      if (fl_total > 0) begin
        h = fl_head % NPG;
        r.page_addr = 32'(b + longint'(h) * PGB);
        fl_head = pg_val[h] % NPG;
        pg_free[h] = 0;
        pg_val[h] = 1;
        fl_total--;
        r.ref_count = 16'd1;
      end else r.status = ST_NOMEM;
    end else if (o == OP_ADD || o == OP_DROP) begin
      if (idx < 0) r.status = ST_RANGE;
      else if (pg_free[idx]) r.status = ST_NALLOC;
      else if (o == OP_ADD) begin
        if (pg_val[idx] >= CNTMAX) r.status = ST_SAT;
        else pg_val[idx]++;
        r.ref_count = 16'(pg_val[idx]);
      end else if (pg_val[idx] <= 1) begin
        pg_val[idx] = fl_head;
        pg_free[idx] = 1;
        fl_head = 32'(idx);
        fl_total++;
      end else begin
        pg_val[idx]--;
        r.ref_count = 16'(pg_val[idx]);
      end
    end else if (o == OP_RSV) begin
      s = ((longint'(a) + PGB - 1) / PGB) * PGB;
      en = (longint'(e) / PGB) * PGB;
      if (en <= s || s < b || en > rend) r.status = ST_RANGE;
      else begin
        p = 32'((s - b) / PGB);
        sz = 32'((en - s) / PGB);
        busy = 0;
        for (int i = p; i < p + sz; i++) if (!pg_free[i]) busy = 1;
        if (busy) r.status = ST_NOMEM;
        else begin
          for (int i = p; i < p + sz; i++) begin
            pg_free[i] = 0;
            pg_val[i] = 1;
          end
          prev = 0;
          tot = 0;
          for (int i = 0; i < npages; i++) if (pg_free[i]) begin
            pg_val[i] = prev;
            prev = i;
            tot++;
          end
          fl_head = prev;
          fl_total = tot;
          r.ref_count = 16'd1;
        end
      end
    end else begin
      if (idx >= 0 && !pg_free[idx]) r.ref_count = 16'(pg_val[idx]);
    end
    r.in_range = idx >= 0;
    r.free_pages = 11'(fl_total);
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_refcounted_page_allocator_core: errors");
      $finish;
    end
  end

  // receiver: random stalls, or a full hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= !hold_out && ($urandom_range(99) >= out_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, page_addr, ref_count, in_range, free_pages};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d pa=%h rc=%0d ir=%0d fp=%0d",
                     want.status, want.page_addr, want.ref_count, want.in_range,
                     want.free_pages,
                     ", got st=%0d pa=%h rc=%0d ir=%0d fp=%0d",
                     got.status, got.page_addr, got.ref_count,
                     got.in_range, got.free_pages);
        end
      end
    end
  end

  task automatic send_op(logic [2:0] o, logic [31:0] a, logic [31:0] e);
    while ($urandom_range(99) < in_idle_pct) @(posedge clk);
    in_valid <= 1;
    op <= o;
    addr <= a;
    end_addr <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_op(o, a, e));
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] i, logic [31:0] d);
    drain();
    cfg_valid <= 1;
    cfg_index <= i;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (i == CFG_BASE) base_reg = d;
    else begin
      npages = 32'(d[10:0]);
      if (npages < 1) npages = 1;
      if (npages > NPG) npages = NPG;
      rebuild_chain();
    end
  endtask

  function automatic logic [31:0] page_of(int unsigned i);
    return 32'(base_al() + longint'(i) * PGB) | 32'($urandom_range(PGB - 1));
  endfunction

  // random address: mostly inside, sometimes anywhere
  function automatic logic [31:0] rand_addr();
    if ($urandom_range(9) < 8) return page_of($urandom_range(npages - 1));
    return $urandom();
  endfunction

  task automatic test_directed();
    write_reg(CFG_BASE, 32'h0000_5abc);
    write_reg(CFG_PCOUNT, 4);
    send_op(OP_ALLOC, 0, 0);
    send_op(OP_ADD, page_of(0), 0);
    send_op(OP_DROP, page_of(0), 0);
    send_op(OP_DROP, page_of(0), 0);
    send_op(OP_DROP, page_of(0), 0);            // drop on a free page: not allocated
    send_op(OP_ADD, 32'h0000_0fff, 0);          // below region
    send_op(OP_ADD, 32'hffff_ffff, 0);          // above region
    send_op(OP_RSV, page_of(1), page_of(3));    // reserve pages 2..2
    send_op(OP_RSV, page_of(2), page_of(3));    // start rounds up to page 3: empty range
    send_op(OP_RSV, page_of(3), page_of(1));    // empty range
    send_op(OP_RSV, 0, 32'hffff_ffff);          // outside
    repeat (4) send_op(OP_ALLOC, 0, 0);         // runs dry
    send_op(OP_QUERY, page_of(2), 0);
    send_op(3'd7, page_of(1), 0);               // unknown op acts as query
    send_op(3'd5, 32'hffff_ffff, 32'hffff_ffff);
    send_op(OP_RSV, page_of(0), page_of(0) + 32'h0001_0000);
  endtask

  task automatic test_ref_counts();
    write_reg(CFG_PCOUNT, 2);
    send_op(OP_ALLOC, 0, 0);
    // a run of add references on one page, no idling
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (40) send_op(OP_ADD, page_of(0), 0);
    send_op(OP_QUERY, page_of(0), 0);
    send_op(OP_DROP, page_of(0), 0);
    in_idle_pct = 29;
    out_idle_pct = 29;
  endtask

  task automatic test_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      in_idle_pct = (i > n / 3 && i < n / 2) ? 0 : 29;
      out_idle_pct = in_idle_pct;
      k = $urandom_range(99);
      if (k < 35) send_op(OP_ALLOC, $urandom(), $urandom());
      else if (k < 55) send_op(OP_ADD, rand_addr(), $urandom());
      else if (k < 80) send_op(OP_DROP, rand_addr(), $urandom());
      else if (k < 88) begin
        logic [31:0] s;
        s = rand_addr();
        send_op(OP_RSV, s, s + $urandom_range(3) * PGB);
      end else if (k < 92) send_op(OP_RSV, $urandom(), $urandom());
      else send_op(3'($urandom_range(4, 7)), rand_addr(), $urandom());
    end
    in_idle_pct = 29;
    out_idle_pct = 29;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_out = 1;
        repeat (300) @(posedge clk);
        hold_out = 0;
      end
      repeat (20) send_op(OP_ALLOC, 0, 0);
    join
    drain();
    repeat (10) send_op(OP_DROP, rand_addr(), 0);
  endtask

  initial begin
    base_reg = 0;
    npages = NPG;
    rebuild_chain();
    repeat (3) @(posedge clk);
    rst <= 0;
    test_directed();
    test_ref_counts();
    write_reg(CFG_BASE, 32'hffff_ffff);
    write_reg(CFG_PCOUNT, 16);
    test_random(250);
    test_backpressure();
    write_reg(CFG_BASE, 32'h8000_0123);
    write_reg(CFG_PCOUNT, 1);
    test_random(60);
    write_reg(CFG_BASE, $urandom());
    write_reg(CFG_PCOUNT, 1024);
    test_random(300);
    write_reg(CFG_PCOUNT, 11'h7ff);
    test_random(40);
    drain();
    if (errors == 0) $display("tb_refcounted_page_allocator_core: clean");
    else $display("tb_refcounted_page_allocator_core: errors");
    $finish;
  end

endmodule

// File: refcounted_page_allocator_core.f
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_ram.sv
hw/rtl/rpa_ctrl.sv
hw/rtl/rpa_dp.sv
hw/rtl/refcounted_page_allocator_core.sv
verif/tb_refcounted_page_allocator_core.sv
